// ----- rtl/websocket_frame_deframer_unit_defines.svh -----
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Shared concurrent assertion forms for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer next-cycle check failed");

`endif

// ----- rtl/wfd_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Parser phases, result kinds and header constants for the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wfd_pkg;

	localparam int LEN_BITS_DEF = 64;

	localparam logic [3:0] OP_CLOSE   = 4'h8;
	localparam logic [6:0] LEN_16     = 7'd126;
	localparam logic [6:0] LEN_64     = 7'd127;
	localparam logic [2:0] EXT16_CNT  = 3'd1;
	localparam logic [2:0] EXT64_CNT  = 3'd7;
	localparam logic [2:0] KEY_CNT    = 3'd3;

	typedef enum logic [5:0] {
		PH_HDR0   = 6'b000001,
		PH_HDR1   = 6'b000010,
		PH_EXT    = 6'b000100,
		PH_KEY    = 6'b001000,
		PH_DATA   = 6'b010000,
		PH_CLOSED = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_CLOSE   = 2'd2
	} kind_t;

endpackage

`default_nettype wire

// ----- rtl/websocket_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer with unmasking
// An accepted byte passes from the input register through the parser to the output register.
// Throughput: one byte per cycle unless the output stalls, via a single-pass parser update.
// Reset: arst_n clears the parser to expect a first header byte and empties both registers.
// A close frame locks the parser out; only reset clears that lockout.
// ----------------------------------------------------------------------------
`default_nettype none

`include "websocket_frame_deframer_unit_defines.svh"

module websocket_frame_deframer_unit #(
	parameter int LEN_BITS = wfd_pkg::LEN_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      kind,
	output logic [7:0]      payload_byte,
	output logic [3:0]      frame_opcode,
	output logic            final_flag,
	output logic            was_masked,
	output logic            last_of_frame
);

	import wfd_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state.
	phase_t              phase_q;
	logic                fin_q;
	logic [3:0]          opcode_q;
	logic                mask_q;
	logic [2:0]          cnt_q;
	logic [31:0]         key_q;
	logic [LEN_BITS-1:0] rem_q;
	logic [1:0]          ki_q;

	// Output register.
	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] payload_q;
	logic [3:0] opcode_out_q;
	logic       fin_out_q;
	logic       masked_out_q;
	logic       last_out_q;

	logic adv;
	logic in_accept;

	phase_t              phase_n;
	logic                fin_n;
	logic [3:0]          opcode_n;
	logic                mask_n;
	logic [2:0]          cnt_n;
	logic [31:0]         key_n;
	logic [LEN_BITS-1:0] rem_n;
	logic [1:0]          ki_n;

	logic       res_v;
	kind_t      res_kind;
	logic [7:0] res_byte;
	logic       res_last;
	logic [7:0] key_byte;

	// The byte in the input register moves on unless a held result blocks the output.
	assign adv       = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		case (ki_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_n  = phase_q;
		fin_n    = fin_q;
		opcode_n = opcode_q;
		mask_n   = mask_q;
		cnt_n    = cnt_q;
		key_n    = key_q;
		rem_n    = rem_q;
		ki_n     = ki_q;
		res_v    = 1'b0;
		res_kind = KIND_PAYLOAD;
		res_byte = 8'd0;
		res_last = 1'b0;
		case (phase_q)
			PH_HDR0: begin
				fin_n    = byte_s1[7];
				opcode_n = byte_s1[3:0];
				mask_n   = 1'b0;
				if (byte_s1[3:0] == OP_CLOSE) begin
					phase_n  = PH_CLOSED;
					res_v    = 1'b1;
					res_kind = KIND_CLOSE;
				end else begin
					phase_n = PH_HDR1;
				end
			end
			PH_HDR1: begin
				mask_n = byte_s1[7];
				if (byte_s1[6:0] == LEN_16) begin
					phase_n = PH_EXT;
					cnt_n   = EXT16_CNT;
					rem_n   = '0;
				end else if (byte_s1[6:0] == LEN_64) begin
					phase_n = PH_EXT;
					cnt_n   = EXT64_CNT;
					rem_n   = '0;
				end else begin
					rem_n = {{(LEN_BITS-7){1'b0}}, byte_s1[6:0]};
					if (byte_s1[7]) begin
						phase_n = PH_KEY;
						cnt_n   = KEY_CNT;
					end else begin
						ki_n = 2'd0;
						if (byte_s1[6:0] == 7'd0) begin
							phase_n  = PH_HDR0;
							res_v    = 1'b1;
							res_kind = KIND_EMPTY;
						end else begin
							phase_n = PH_DATA;
						end
					end
				end
			end
			PH_EXT: begin
				// Big-endian length: bytes above the register width fall off the top.
				rem_n = {rem_q[LEN_BITS-9:0], byte_s1};
				if (cnt_q == 3'd0) begin
					if (mask_q) begin
						phase_n = PH_KEY;
						cnt_n   = KEY_CNT;
					end else begin
						ki_n = 2'd0;
						if (rem_n == '0) begin
							phase_n  = PH_HDR0;
							res_v    = 1'b1;
							res_kind = KIND_EMPTY;
						end else begin
							phase_n = PH_DATA;
						end
					end
				end else begin
					cnt_n = cnt_q - 3'd1;
				end
			end
			PH_KEY: begin
				key_n = {key_q[23:0], byte_s1};
				if (cnt_q == 3'd0) begin
					ki_n = 2'd0;
					if (rem_q == '0) begin
						phase_n  = PH_HDR0;
						res_v    = 1'b1;
						res_kind = KIND_EMPTY;
					end else begin
						phase_n = PH_DATA;
					end
				end else begin
					cnt_n = cnt_q - 3'd1;
				end
			end
			PH_DATA: begin
				ki_n     = ki_q + 2'd1;
				rem_n    = rem_q - {{(LEN_BITS-1){1'b0}}, 1'b1};
				res_v    = 1'b1;
				res_kind = KIND_PAYLOAD;
				res_byte = mask_q ? (byte_s1 ^ key_byte) : byte_s1;
				res_last = (rem_n == '0);
				if (rem_n == '0) begin
					phase_n = PH_HDR0;
				end
			end
			PH_CLOSED: begin
				phase_n = PH_CLOSED;
			end
			default: begin
				phase_n = PH_HDR0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fin_q    <= 1'b0;
			opcode_q <= 4'd0;
			mask_q   <= 1'b0;
			cnt_q    <= 3'd0;
			key_q    <= 32'd0;
			rem_q    <= '0;
			ki_q     <= 2'd0;
		end else if (adv) begin
			phase_q  <= phase_n;
			fin_q    <= fin_n;
			opcode_q <= opcode_n;
			mask_q   <= mask_n;
			cnt_q    <= cnt_n;
			key_q    <= key_n;
			rem_q    <= rem_n;
			ki_q     <= ki_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_v) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_v) begin
			kind_q       <= res_kind;
			payload_q    <= res_byte;
			opcode_out_q <= opcode_n;
			fin_out_q    <= fin_n;
			masked_out_q <= mask_n;
			last_out_q   <= res_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign payload_byte  = payload_q;
	assign frame_opcode  = opcode_out_q;
	assign final_flag    = fin_out_q;
	assign was_masked    = masked_out_q;
	assign last_of_frame = last_out_q;

	`WFD_ASSERT_NEXT(a_closed_sticky, clk, arst_n, phase_q == PH_CLOSED, phase_q == PH_CLOSED)
	`WFD_ASSERT_NOW(a_data_has_length, clk, arst_n, phase_q == PH_DATA, rem_q != '0)
	`WFD_ASSERT_NOW(a_stall_needs_held_result, clk, arst_n, in_stall,
		valid_s1 && out_valid_q && out_stall)
	`WFD_ASSERT_NEXT(a_closed_no_result, clk, arst_n,
		phase_q == PH_CLOSED && out_valid_q && !out_stall, !out_valid_q)

endmodule

`default_nettype wire
